// ===== design/cke_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cke_pkg: shared definitions for the canonical k-mer encoder
// Nucleotide byte codes, decode function, defaults and control types.
// ----------------------------------------------------------------------------
package cke_pkg;

  // default largest k-mer length in bases
  localparam int MAX_K_DFLT = 32;

  // width of the length register and its reset value
  localparam int KMER_LEN_W = 6;
  localparam logic [KMER_LEN_W-1:0] KMER_LEN_RST = 6'd31;

  // result field width
  localparam int KMER_OUT_W = 64;

  // ascii nucleotide letters
  localparam logic [7:0] CH_A_UP = 8'h41;
  localparam logic [7:0] CH_C_UP = 8'h43;
  localparam logic [7:0] CH_G_UP = 8'h47;
  localparam logic [7:0] CH_T_UP = 8'h54;
  localparam logic [7:0] CH_A_LO = 8'h61;
  localparam logic [7:0] CH_C_LO = 8'h63;
  localparam logic [7:0] CH_G_LO = 8'h67;
  localparam logic [7:0] CH_T_LO = 8'h74;

  // 2-bit base codes
  localparam logic [1:0] BASE_A = 2'd0;
  localparam logic [1:0] BASE_C = 2'd1;
  localparam logic [1:0] BASE_G = 2'd2;
  localparam logic [1:0] BASE_T = 2'd3;

  // decoded base: ok is low for anything that is not a nucleotide
  typedef struct packed {
    logic       ok;
    logic [1:0] code;
  } base_dec_t;

  // per-request control into the rolling code unit
  typedef struct packed {
    logic      step;
    logic      record_start;
    base_dec_t base;
  } roll_ctl_t;

  function automatic base_dec_t decode_base(input logic [7:0] b);
    base_dec_t d;
    d.ok   = 1'b1;
    d.code = BASE_A;
    unique case (b) inside
      CH_A_UP, CH_A_LO: d.code = BASE_A;
      CH_C_UP, CH_C_LO: d.code = BASE_C;
      CH_G_UP, CH_G_LO: d.code = BASE_G;
      CH_T_UP, CH_T_LO: d.code = BASE_T;
      default:          d.ok   = 1'b0;
    endcase
    return d;
  endfunction

endpackage
`default_nettype wire

// ===== design/cke_roll.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cke_roll: rolling forward and reverse-complement codes
// Holds both codes and the valid-base run, and forms the canonical k-mer.
// ----------------------------------------------------------------------------
module cke_roll #(
  parameter int MAX_K = 32,
  parameter int KW    = $clog2(MAX_K + 1),
  parameter int CW    = 2 * MAX_K
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire cke_pkg::roll_ctl_t ctl,
  input  wire logic             clear_run,
  input  wire logic [KW-1:0]    k,
  output logic                  emit,
  output logic [CW-1:0]         kmer
);
  import cke_pkg::*;

  logic [CW-1:0] fwd;
  logic [CW-1:0] rev;
  logic [KW-1:0] run;
  logic [CW-1:0] fwd_next;
  logic [CW-1:0] rev_next;
  logic [KW-1:0] run_next;
  logic [KW-1:0] run_base;
  logic [CW-1:0] fwd_sh;
  logic [CW-1:0] rev_sh;

  // shift codes and mask to 2k bits
  // complement is or-ed into the top slot, which still holds old bits after k shrinks
  always_comb begin
    fwd_sh = CW'({fwd, ctl.base.code});
    rev_sh = rev >> 2;
    for (int j = 0; j < MAX_K; j++) begin
      if (KW'(j + 1) == k) begin
        rev_sh[2*j +: 2] = rev_sh[2*j +: 2] | ~ctl.base.code;
      end
      if (KW'(j) < k) begin
        fwd_next[2*j +: 2] = fwd_sh[2*j +: 2];
        rev_next[2*j +: 2] = rev_sh[2*j +: 2];
      end else begin
        fwd_next[2*j +: 2] = 2'b00;
        rev_next[2*j +: 2] = 2'b00;
      end
    end
  end

  // run of valid bases, saturating at k
  always_comb begin
    run_base = ctl.record_start ? '0 : run;
    if (!ctl.base.ok) begin
      run_next = '0;
    end else if (run_base < k) begin
      run_next = run_base + KW'(1);
    end else begin
      run_next = run_base;
    end
  end

  assign emit = ctl.base.ok && (run_next >= k);
  assign kmer = (fwd_next < rev_next) ? fwd_next : rev_next;

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd <= '0;
      rev <= '0;
      run <= '0;
    end else if (ctl.step) begin
      run <= run_next;
      if (ctl.base.ok) begin
        fwd <= fwd_next;
        rev <= rev_next;
      end
    end else if (clear_run) begin
      run <= '0;
    end
  end

endmodule
`default_nettype wire

// ===== design/canonical_kmer_encoder.sv =====
`timescale 1ns / 1ps
`default_nettype none
// A request is captured in the input register, its result then in the output register.
// Throughput: one byte per cycle while in_stall is low; the rolling code update and the 2k-bit
// min compare sit between the input register and the output register.
// Reset: synchronous; codes, run and valid flags cleared, length register back to 31.
// Output register stalls propagate to in_stall within the same cycle.
// ----------------------------------------------------------------------------
// canonical_kmer_encoder: streaming canonical 2-bit k-mer encoder
// Byte stream in, min of forward and reverse-complement k-mer codes out.
// ----------------------------------------------------------------------------
module canonical_kmer_encoder #(
  parameter int MAX_K = cke_pkg::MAX_K_DFLT
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [cke_pkg::KMER_LEN_W-1:0] kmer_len,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [7:0]                     base_byte,
  input  wire logic                           record_start,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [cke_pkg::KMER_OUT_W-1:0]      canonical_kmer
);
  import cke_pkg::*;

  localparam int KW = $clog2(MAX_K + 1);
  localparam int CW = 2 * MAX_K;

  logic [KMER_LEN_W-1:0] klen;
  logic [KW-1:0]         k_eff;
  logic                  s1_valid;
  logic [7:0]            s1_byte;
  logic                  s1_start;
  logic                  out_free;
  logic                  s1_fire;
  logic                  in_take;
  logic                  cfg_take;
  roll_ctl_t             ctl;
  logic                  emit;
  logic [CW-1:0]         kmer;

  assign cfg_ready = 1'b1;
  assign cfg_take  = cfg_valid && cfg_ready;

  // length register
  always_ff @(posedge clk) begin
    if (rst) begin
      klen <= KMER_LEN_RST;
    end else if (cfg_take) begin
      klen <= kmer_len;
    end
  end

  // clamp length to 1..MAX_K
  always_comb begin
    if (klen == '0) begin
      k_eff = KW'(1);
    end else if (klen > KMER_LEN_W'(MAX_K)) begin
      k_eff = KW'(MAX_K);
    end else begin
      k_eff = KW'(klen);
    end
  end

  // handshake
  assign out_free = !out_valid || !out_stall;
  assign s1_fire  = s1_valid && out_free;
  assign in_stall = s1_valid && !out_free;
  assign in_take  = in_valid && !in_stall;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte  <= base_byte;
      s1_start <= record_start;
    end
  end

  // rolling code unit
  assign ctl.step         = s1_fire;
  assign ctl.record_start = s1_start;
  assign ctl.base         = decode_base(s1_byte);

  cke_roll #(
    .MAX_K (MAX_K),
    .KW    (KW),
    .CW    (CW)
  ) u_roll (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .clear_run (cfg_take),
    .k         (k_eff),
    .emit      (emit),
    .kmer      (kmer)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_fire && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s1_fire && emit) begin
      canonical_kmer <= KMER_OUT_W'(kmer);
    end
  end

endmodule
`default_nettype wire

// ===== bench/tb_canonical_kmer_encoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_canonical_kmer_encoder: self-checking bench for the canonical k-mer encoder
// Streams DNA bytes through the block under several k-mer lengths and checks
// each emitted k-mer against a rolling-code predictor, with random input gaps
// and random output stalls.
// ----------------------------------------------------------------------------
module tb_canonical_kmer_encoder;
  import cke_pkg::*;

  localparam int MAX_K      = MAX_K_DFLT;
  localparam int NOT_A_BASE = 4;
  localparam int DRAIN_CYC  = 8;

  logic                  clk;
  logic                  rst;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [KMER_LEN_W-1:0] kmer_len;
  logic                  in_valid;
  logic                  in_stall;
  logic [7:0]            base_byte;
  logic                  record_start;
  logic                  out_valid;
  logic                  out_stall;
  logic [KMER_OUT_W-1:0] canonical_kmer;

  // predictor state
  logic [KMER_LEN_W-1:0] len_reg;
  logic [63:0]           fwd_code;
  logic [63:0]           rc_code;
  int unsigned           run_len;
  logic [63:0]           expected_kmers[$];
  int                    mismatches;

  logic [7:0] letters[8] = '{CH_A_UP, CH_C_UP, CH_G_UP, CH_T_UP,
                             CH_A_LO, CH_C_LO, CH_G_LO, CH_T_LO};

  canonical_kmer_encoder #(.MAX_K(MAX_K)) DUT (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .kmer_len       (kmer_len),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .base_byte      (base_byte),
    .record_start   (record_start),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .canonical_kmer (canonical_kmer)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // 2-bit code of a byte, or NOT_A_BASE
  function automatic int nucleotide_code(input logic [7:0] b);
    case (b)
      CH_A_UP, CH_A_LO: return int'(BASE_A);
      CH_C_UP, CH_C_LO: return int'(BASE_C);
      CH_G_UP, CH_G_LO: return int'(BASE_G);
      CH_T_UP, CH_T_LO: return int'(BASE_T);
      default:          return NOT_A_BASE;
    endcase
  endfunction

  // roll one accepted byte into the codes and queue the k-mer it completes
  function automatic void roll_base(input logic [7:0] b, input logic rs);
    int unsigned k;
    logic [63:0] mask;
    int          code;
    k = 32'(len_reg);
    if (k < 1) k = 1;
    if (k > MAX_K) k = MAX_K;
    mask = (k >= 32) ? '1 : ((64'd1 << (2 * k)) - 64'd1);
    code = nucleotide_code(b);
    if (rs) run_len = 0;
    if (code == NOT_A_BASE) begin
      run_len = 0;
      return;
    end
    fwd_code = ((fwd_code << 2) | 64'(code)) & mask;
    // complement enters at the top of the window
    rc_code  = ((rc_code >> 2) | (64'(int'(BASE_T) - code) << (2 * (k - 1)))) & mask;
    if (run_len < k) run_len++;
    if (run_len >= k)
      expected_kmers = {expected_kmers, ((fwd_code < rc_code) ? fwd_code : rc_code)};
  endfunction

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic idle_cycles(input int n);
    repeat (n) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
  endtask

  // one byte request, held until accepted
  task automatic send_byte(input logic [7:0] b, input logic rs);
    @(negedge clk);
    in_valid     <= 1'b1;
    base_byte    <= b;
    record_start <= rs;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    roll_base(b, rs);
  endtask

  task automatic wait_results();
    while (expected_kmers.size() != 0) @(posedge clk);
  endtask

  // stop sending and let the pipeline empty
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    wait_results();
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  task automatic write_kmer_len(input logic [KMER_LEN_W-1:0] v);
    settle();
    @(negedge clk);
    cfg_valid <= 1'b1;
    kmer_len  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    len_reg = v;
    run_len = 0;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // random stream: mostly nucleotides, some noise and record starts
  task automatic run_random_phase(input logic [KMER_LEN_W-1:0] len, input bit set_len,
                                  input int n_items);
    int   noise_pct;
    int   rs_pct;
    bit   no_idle;
    logic [7:0] b;
    logic rs;
    if (set_len) write_kmer_len(len);
    noise_pct = (len >= 12) ? 1 : 6;
    rs_pct    = (len >= 12) ? 1 : 4;
    no_idle   = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < n_items; i++) begin
      if ($urandom_range(0, 99) < noise_pct) b = 8'($urandom_range(0, 255));
      else b = letters[$urandom_range(0, 7)];
      rs = ($urandom_range(0, 99) < rs_pct);
      if (!no_idle) idle_cycles(pick_gap());
      // hold off mid-phase until every k-mer has come out
      if (i == n_items / 2) begin
        idle_cycles(1);
        wait_results();
      end
      send_byte(b, rs);
    end
  endtask

  task automatic test_reset_length();
    run_random_phase(KMER_LEN_RST, 1'b0, 80);
  endtask

  task automatic test_base_letters();
    logic [7:0] odd_bytes[4] = '{8'h4E, 8'hC1, 8'h00, 8'hFF};
    write_kmer_len(6'd1);
    foreach (letters[i]) send_byte(letters[i], 1'b0);
    foreach (odd_bytes[i]) send_byte(odd_bytes[i], 1'b0);
  endtask

  // a length of zero acts as one
  task automatic test_zero_length();
    write_kmer_len(6'd0);
    send_byte(CH_G_UP, 1'b1);
    send_byte(8'hC7, 1'b1);
    send_byte(CH_T_LO, 1'b0);
  endtask

  task automatic test_short_window();
    write_kmer_len(6'd3);
    send_byte(CH_A_UP, 1'b0);
    send_byte(CH_C_UP, 1'b0);
    send_byte(CH_G_UP, 1'b0);
    send_byte(CH_T_UP, 1'b0);
    send_byte(8'h4E, 1'b0);
    send_byte(CH_A_LO, 1'b0);
    send_byte(CH_C_LO, 1'b0);
    send_byte(CH_G_LO, 1'b0);
    // record start mid-run restarts the count
    send_byte(CH_T_UP, 1'b1);
    send_byte(CH_G_UP, 1'b0);
    send_byte(CH_C_UP, 1'b0);
  endtask

  // a length write drops the partial run
  task automatic test_config_clears_run();
    send_byte(CH_A_UP, 1'b0);
    send_byte(CH_C_UP, 1'b0);
    write_kmer_len(6'd3);
    send_byte(CH_G_UP, 1'b0);
    send_byte(CH_T_UP, 1'b0);
    send_byte(CH_A_UP, 1'b0);
  endtask

  task automatic test_random_stream();
    logic [KMER_LEN_W-1:0] lens[12] = '{6'd32, 6'd63, 6'd1, 6'd0, 6'd2, 6'd4,
                                        6'd33, 6'd7, 6'd3, 6'd16, 6'd5, 6'd10};
    foreach (lens[i]) run_random_phase(lens[i], 1'b1, 85);
  endtask

  // output stall in stretches: none, light, even, heavy
  initial begin
    int seg;
    int mode;
    out_stall = 1'b0;
    forever begin
      seg  = $urandom_range(20, 200);
      mode = $urandom_range(0, 3);
      repeat (seg) begin
        @(negedge clk);
        case (mode)
          0:       out_stall <= 1'b0;
          1:       out_stall <= ($urandom_range(0, 3) == 0);
          2:       out_stall <= ($urandom_range(0, 1) == 0);
          default: out_stall <= ($urandom_range(0, 19) < 17);
        endcase
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    logic [63:0] want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_kmers.size() == 0) begin
        $error("canonical_kmer: unexpected result %h", canonical_kmer);
        mismatches++;
      end else begin
        want = expected_kmers.pop_front();
        if (canonical_kmer !== want) begin
          $error("canonical_kmer: expected %h, got %h", want, canonical_kmer);
          mismatches++;
        end
      end
    end
  end

  // main sequence
  initial begin
    rst          = 1'b1;
    cfg_valid    = 1'b0;
    kmer_len     = '0;
    in_valid     = 1'b0;
    base_byte    = '0;
    record_start = 1'b0;
    len_reg      = KMER_LEN_RST;
    fwd_code     = '0;
    rc_code      = '0;
    run_len      = 0;
    mismatches   = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_length();
    test_base_letters();
    test_zero_length();
    test_short_window();
    test_config_clears_run();
    test_random_stream();

    settle();
    repeat (DRAIN_CYC) @(posedge clk);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
